FILE: sv/mtw_pkg.sv
package mtw_pkg;

  localparam int ID_W    = 8;
  localparam int TIME_W  = 32;
  localparam int ELAPS_W = 16;

  localparam logic [1:0] ACT_REGISTER = 2'd0;
  localparam logic [1:0] ACT_CHECKIN  = 2'd1;
  localparam logic [1:0] ACT_SCAN     = 2'd2;
  localparam logic [1:0] ACT_NONE     = 2'd3;

  localparam logic [1:0] KIND_REGISTER = 2'd0;
  localparam logic [1:0] KIND_CHECKIN  = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT  = 2'd2;
  localparam logic [1:0] KIND_DONE     = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic CFG_TIMEOUT    = 1'b0;
  localparam logic CFG_RESET_MODE = 1'b1;

  localparam logic [TIME_W-1:0] TIMEOUT_DEFAULT = 32'd1000;

  typedef struct packed {
    logic load;
    logic rd_issue;
    logic rd_inc;
    logic found;
    logic keep;
    logic report;
    logic clear;
    logic commit;
    logic done;
    logic answer;
  } mtw_cmd_t;

  typedef struct packed {
    logic [1:0] in_action;
    logic       more;
    logic       match;
    logic       expired;
    logic       reset_mode;
    logic       out_free;
  } mtw_sts_t;

endpackage

FILE: sv/mtw_in_if.sv
interface mtw_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [mtw_pkg::ID_W-1:0] task_id;
  logic [mtw_pkg::ELAPS_W-1:0] elapsed;

  modport source (output valid, output action, output task_id, output elapsed, input ready);
  modport sink   (input valid, input action, input task_id, input elapsed, output ready);
endinterface

FILE: sv/mtw_out_if.sv
interface mtw_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [1:0]               status;
  logic [mtw_pkg::ID_W-1:0] task_id_res;
  logic                     system_reset;
  logic                     last;

  modport source (output valid, output kind, output status, output task_id_res,
                  output system_reset, output last, input ready);
  modport sink   (input valid, input kind, input status, input task_id_res,
                  input system_reset, input last, output ready);
endinterface

FILE: sv/mtw_cfg_if.sv
interface mtw_cfg_if;
  logic                       valid;
  logic                       ready;
  logic                       index;
  logic [mtw_pkg::TIME_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/mtw_ctrl.sv
module mtw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mtw_pkg::mtw_sts_t sts,
  output mtw_pkg::mtw_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LK_RD  = 3'd1;
  localparam logic [2:0] S_LK_CMP = 3'd2;
  localparam logic [2:0] S_ANSWER = 3'd3;
  localparam logic [2:0] S_SC_RD  = 3'd4;
  localparam logic [2:0] S_SC_CMP = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (sts.in_action)
            mtw_pkg::ACT_REGISTER: state_nxt = S_LK_RD;
            mtw_pkg::ACT_CHECKIN:  state_nxt = S_LK_RD;
            mtw_pkg::ACT_SCAN:     state_nxt = S_SC_RD;
            default:               state_nxt = S_IDLE;
          endcase
        end
      end
      S_LK_RD: begin
        if (sts.more) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_LK_CMP;
        end else begin
          state_nxt = S_ANSWER;
        end
      end
      S_LK_CMP: begin
        if (sts.match) begin
          cmd.found = 1'b1;
          state_nxt = S_ANSWER;
        end else begin
          cmd.rd_inc = 1'b1;
          state_nxt  = S_LK_RD;
        end
      end
      S_ANSWER: begin
        if (sts.out_free) begin
          cmd.answer = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SC_RD: begin
        if (sts.more) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_SC_CMP;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_SC_CMP: begin
        if (sts.expired) begin
          if (sts.out_free) begin
            cmd.report = 1'b1;
            cmd.rd_inc = 1'b1;
            if (sts.reset_mode) begin
              cmd.clear = 1'b1;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SC_RD;
            end
          end
        end else begin
          cmd.keep   = 1'b1;
          cmd.rd_inc = 1'b1;
          state_nxt  = S_SC_RD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.answer || cmd.report || cmd.done) |-> sts.out_free)
    else $error("Result issued while the output register is occupied.");

  a_single_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.answer, cmd.report, cmd.done}))
    else $error("More than one result issued in a cycle.");

  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && sts.in_action != mtw_pkg::ACT_NONE) |=> !in_ready)
    else $error("Input accepted again before the transaction was answered.");

endmodule

FILE: sv/mtw_dp.sv
module mtw_dp #(
  parameter int MAX_TASKS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mtw_pkg::mtw_cmd_t             cmd,
  output mtw_pkg::mtw_sts_t             sts,
  input  logic [1:0]                    in_action,
  input  logic [mtw_pkg::ID_W-1:0]      in_task_id,
  input  logic [mtw_pkg::ELAPS_W-1:0]   in_elapsed,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [mtw_pkg::TIME_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [1:0]                    out_status,
  output logic [mtw_pkg::ID_W-1:0]      out_task_id_res,
  output logic                          out_system_reset,
  output logic                          out_last
);

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int EW = mtw_pkg::ID_W + mtw_pkg::TIME_W;

  logic [EW-1:0] mem [MAX_TASKS];
  logic [EW-1:0] rdata_r;

  logic [mtw_pkg::TIME_W-1:0] time_r, time_nxt;
  logic [mtw_pkg::TIME_W-1:0] timeout_r;
  logic                       reset_mode_r;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              rd_r, rd_nxt;
  logic [CW-1:0]              wr_r, wr_nxt;
  logic                       found_r, found_nxt;
  logic [1:0]                 act_r;
  logic [mtw_pkg::ID_W-1:0]   id_r;
  logic                       out_valid_r, out_valid_nxt;

  logic [1:0]                 kind_r, status_r;
  logic [mtw_pkg::ID_W-1:0]   tid_r;
  logic                       sysrst_r, last_r;

  logic [mtw_pkg::ID_W-1:0]   rd_id;
  logic [mtw_pkg::TIME_W-1:0] rd_stamp;
  logic                       full;
  logic                       append;
  logic                       we;
  logic [AW-1:0]              wa;
  logic [EW-1:0]              wdata;
  logic                       emit;

  assign rd_id    = rdata_r[EW-1:mtw_pkg::TIME_W];
  assign rd_stamp = rdata_r[mtw_pkg::TIME_W-1:0];
  assign full     = (count_r == CW'(MAX_TASKS));
  assign append   = cmd.answer && (act_r == mtw_pkg::ACT_REGISTER) && !found_r && !full;
  assign emit     = cmd.answer || cmd.report || cmd.done;

  assign sts.in_action  = in_action;
  assign sts.more       = (rd_r < count_r);
  assign sts.match      = (rd_id == id_r);
  assign sts.expired    = ((time_r - rd_stamp) > timeout_r);
  assign sts.reset_mode = reset_mode_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    we    = 1'b0;
    wa    = wr_r[AW-1:0];
    wdata = {id_r, time_r};
    if (cmd.keep) begin
      we    = 1'b1;
      wdata = rdata_r;
    end else if (append) begin
      we = 1'b1;
      wa = count_r[AW-1:0];
    end else if (cmd.answer && (act_r == mtw_pkg::ACT_CHECKIN) && found_r) begin
      we = 1'b1;
      wa = rd_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wdata;
    end
    if (cmd.rd_issue) begin
      rdata_r <= mem[rd_r[AW-1:0]];
    end
  end

  always_comb begin
    time_nxt      = time_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    found_nxt     = found_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      time_nxt  = time_r + mtw_pkg::TIME_W'(in_elapsed);
      rd_nxt    = '0;
      wr_nxt    = '0;
      found_nxt = 1'b0;
    end
    if (cmd.rd_inc) begin
      rd_nxt = rd_r + CW'(1);
    end
    if (cmd.keep) begin
      wr_nxt = wr_r + CW'(1);
    end
    if (cmd.found) begin
      found_nxt = 1'b1;
    end
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.commit) begin
      count_nxt = wr_r;
    end else if (append) begin
      count_nxt = count_r + CW'(1);
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r       <= '0;
      timeout_r    <= mtw_pkg::TIMEOUT_DEFAULT;
      reset_mode_r <= 1'b0;
      count_r      <= '0;
      rd_r         <= '0;
      wr_r         <= '0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      time_r      <= time_nxt;
      count_r     <= count_nxt;
      rd_r        <= rd_nxt;
      wr_r        <= wr_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          mtw_pkg::CFG_TIMEOUT:    timeout_r    <= cfg_data;
          mtw_pkg::CFG_RESET_MODE: reset_mode_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      id_r  <= in_task_id;
    end
    if (cmd.answer) begin
      kind_r   <= (act_r == mtw_pkg::ACT_REGISTER) ? mtw_pkg::KIND_REGISTER
                                                   : mtw_pkg::KIND_CHECKIN;
      if (act_r == mtw_pkg::ACT_REGISTER) begin
        status_r <= found_r ? mtw_pkg::ST_MISS : (full ? mtw_pkg::ST_FULL : mtw_pkg::ST_OK);
      end else begin
        status_r <= found_r ? mtw_pkg::ST_OK : mtw_pkg::ST_MISS;
      end
      tid_r    <= id_r;
      sysrst_r <= 1'b0;
      last_r   <= 1'b1;
    end else if (cmd.report) begin
      kind_r   <= mtw_pkg::KIND_TIMEOUT;
      status_r <= mtw_pkg::ST_OK;
      tid_r    <= rd_id;
      sysrst_r <= reset_mode_r;
      last_r   <= 1'b0;
    end else if (cmd.done) begin
      kind_r   <= mtw_pkg::KIND_DONE;
      status_r <= mtw_pkg::ST_OK;
      tid_r    <= '0;
      sysrst_r <= 1'b0;
      last_r   <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_status       = status_r;
  assign out_task_id_res  = tid_r;
  assign out_system_reset = sysrst_r;
  assign out_last         = last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TASKS))
    else $error("Entry count exceeds the table depth.");

  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    wr_r <= rd_r)
    else $error("Compaction write pointer overtook the read pointer.");

  a_found_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (rd_r < count_r))
    else $error("Matched entry lies outside the occupied table.");

endmodule

FILE: sv/multi_task_watchdog_core.sv
// Register and check-in transactions read then compare each table entry in turn and stop
// at a match; the answer is registered once the output register is free.
// A scan reads then compares each entry, reports and drops expired ones, and ends with a done result.
// Output stalls hold the walk; new input is accepted in the cycle after the last result.
// Table reads are registered, so each entry is read then compared; an unused action only adds time.
// Synchronous active-low reset clears time and count, sets timeout 1000 and reset mode off.
module multi_task_watchdog_core #(
  parameter int MAX_TASKS = 16
) (
  input logic        clk,
  input logic        rst_n,
  mtw_in_if.sink     in_chan,
  mtw_out_if.source  out_chan,
  mtw_cfg_if.sink    cfg_chan
);

  mtw_pkg::mtw_cmd_t cmd;
  mtw_pkg::mtw_sts_t sts;

  assign cfg_chan.ready = 1'b1;

  mtw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mtw_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_chan.action),
    .in_task_id       (in_chan.task_id),
    .in_elapsed       (in_chan.elapsed),
    .cfg_we           (cfg_chan.valid),
    .cfg_index        (cfg_chan.index),
    .cfg_data         (cfg_chan.data),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_kind         (out_chan.kind),
    .out_status       (out_chan.status),
    .out_task_id_res  (out_chan.task_id_res),
    .out_system_reset (out_chan.system_reset),
    .out_last         (out_chan.last)
  );

endmodule

FILE: verif/multi_task_watchdog_core_tb.sv
module multi_task_watchdog_core_tb;

  localparam int TABLE_DEPTH = 16;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [1:0]               kind;
    logic [1:0]               status;
    logic [mtw_pkg::ID_W-1:0] task_id;
    logic                     sys_rst;
    logic                     last;
  } wd_result_t;

  logic clk;
  logic rst_n;

  mtw_in_if  in_chan ();
  mtw_out_if out_chan ();
  mtw_cfg_if cfg_chan ();

  multi_task_watchdog_core #(
    .MAX_TASKS(TABLE_DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  logic [mtw_pkg::TIME_W-1:0] tick_count;
  logic [mtw_pkg::TIME_W-1:0] timeout_limit;
  logic                       reset_mode;
  int                         tbl_len;
  logic [mtw_pkg::ID_W-1:0]   tbl_id    [TABLE_DEPTH];
  logic [mtw_pkg::TIME_W-1:0] tbl_stamp [TABLE_DEPTH];

  wd_result_t pending_results[$];

  int errors;
  int items_sent;
  int results_seen;
  int timeouts_seen;
  int resets_seen;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  function automatic void push_result(logic [1:0] kind, logic [1:0] status,
                                      logic [mtw_pkg::ID_W-1:0] id, logic sys_rst,
                                      logic last);
    wd_result_t r;
    r.kind    = kind;
    r.status  = status;
    r.task_id = id;
    r.sys_rst = sys_rst;
    r.last    = last;
    pending_results.push_back(r);
  endfunction

  function automatic void watchdog_predict(logic [1:0] act, logic [mtw_pkg::ID_W-1:0] id,
                                           logic [mtw_pkg::ELAPS_W-1:0] el);
    int pos;
    int i;
    int j;
    logic [mtw_pkg::TIME_W-1:0] age;
    tick_count = tick_count + mtw_pkg::TIME_W'(el);
    pos = -1;
    for (i = 0; i < tbl_len; i++) begin
      if (pos < 0 && tbl_id[i] == id) pos = i;
    end
    case (act)
      mtw_pkg::ACT_REGISTER: begin
        if (pos >= 0) begin
          push_result(mtw_pkg::KIND_REGISTER, mtw_pkg::ST_MISS, id, 1'b0, 1'b1);
        end else if (tbl_len >= TABLE_DEPTH) begin
          push_result(mtw_pkg::KIND_REGISTER, mtw_pkg::ST_FULL, id, 1'b0, 1'b1);
        end else begin
          tbl_id[tbl_len]    = id;
          tbl_stamp[tbl_len] = tick_count;
          tbl_len++;
          push_result(mtw_pkg::KIND_REGISTER, mtw_pkg::ST_OK, id, 1'b0, 1'b1);
        end
      end
      mtw_pkg::ACT_CHECKIN: begin
        if (pos >= 0) begin
          tbl_stamp[pos] = tick_count;
          push_result(mtw_pkg::KIND_CHECKIN, mtw_pkg::ST_OK, id, 1'b0, 1'b1);
        end else begin
          push_result(mtw_pkg::KIND_CHECKIN, mtw_pkg::ST_MISS, id, 1'b0, 1'b1);
        end
      end
      mtw_pkg::ACT_SCAN: begin
        i = 0;
        while (i < tbl_len) begin
          age = tick_count - tbl_stamp[i];
          if (age > timeout_limit) begin
            if (reset_mode) begin
              push_result(mtw_pkg::KIND_TIMEOUT, mtw_pkg::ST_OK, tbl_id[i], 1'b1, 1'b0);
              tbl_len = 0;
            end else begin
              push_result(mtw_pkg::KIND_TIMEOUT, mtw_pkg::ST_OK, tbl_id[i], 1'b0, 1'b0);
              for (j = i; j + 1 < tbl_len; j++) begin
                tbl_id[j]    = tbl_id[j + 1];
                tbl_stamp[j] = tbl_stamp[j + 1];
              end
              tbl_len--;
            end
          end else begin
            i++;
          end
        end
        push_result(mtw_pkg::KIND_DONE, mtw_pkg::ST_OK, '0, 1'b0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    wd_result_t got;
    wd_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.kind    = out_chan.kind;
      got.status  = out_chan.status;
      got.task_id = out_chan.task_id_res;
      got.sys_rst = out_chan.system_reset;
      got.last    = out_chan.last;
      results_seen++;
      if (got.kind == mtw_pkg::KIND_TIMEOUT) timeouts_seen++;
      if (got.sys_rst) resets_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d id %0d",
                 $time, got.kind, got.task_id);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("status", want.status, got.status);
        check_field("task_id_res", want.task_id, got.task_id);
        check_field("system_reset", want.sys_rst, got.sys_rst);
        check_field("last", want.last, got.last);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_chan.ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_chan.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [mtw_pkg::ID_W-1:0] id,
                           input logic [mtw_pkg::ELAPS_W-1:0] el);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.action  = act;
    in_chan.task_id = id;
    in_chan.elapsed = el;
    in_chan.valid   = 1'b1;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    watchdog_predict(act, id, el);
    items_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [mtw_pkg::TIME_W-1:0] data);
    @(negedge clk);
    cfg_chan.index = idx;
    cfg_chan.data  = data;
    cfg_chan.valid = 1'b1;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    if (idx == mtw_pkg::CFG_TIMEOUT) timeout_limit = data;
    else reset_mode = data[0];
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: expected %0d more results, actual none arrived", $time,
               pending_results.size());
      errors++;
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_table_basics();
    logic [mtw_pkg::ID_W-1:0] fill_ids [TABLE_DEPTH];
    int i;
    fill_ids = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                 8'h40, 8'h80, 8'hAA, 8'h55, 8'h0F, 8'hF0, 8'h33, 8'hCC};
    send_item(mtw_pkg::ACT_CHECKIN, 8'h5A, 16'd0);
    send_item(mtw_pkg::ACT_SCAN, 8'h00, 16'd0);
    for (i = 0; i < TABLE_DEPTH; i++) begin
      send_item(mtw_pkg::ACT_REGISTER, fill_ids[i], (i == 8) ? 16'hFFFF : 16'd0);
    end
    send_item(mtw_pkg::ACT_REGISTER, 8'h55, 16'd0);
    send_item(mtw_pkg::ACT_REGISTER, 8'h77, 16'd0);
    send_item(mtw_pkg::ACT_CHECKIN, 8'h02, 16'd0);
    send_item(mtw_pkg::ACT_CHECKIN, 8'h08, 16'd0);
    send_item(mtw_pkg::ACT_CHECKIN, 8'h77, 16'd0);
    send_item(mtw_pkg::ACT_NONE, 8'hFF, 16'd500);
    send_item(mtw_pkg::ACT_SCAN, 8'h00, 16'd0);
    wait_idle();
  endtask

  task automatic test_reset_mode();
    write_reg(mtw_pkg::CFG_RESET_MODE, 32'd1);
    send_item(mtw_pkg::ACT_SCAN, 8'h00, 16'd2000);
    send_item(mtw_pkg::ACT_SCAN, 8'h00, 16'd0);
    send_item(mtw_pkg::ACT_REGISTER, 8'h99, 16'd0);
    wait_idle();
    write_reg(mtw_pkg::CFG_RESET_MODE, 32'd0);
  endtask

  task automatic test_timeout_extremes();
    write_reg(mtw_pkg::CFG_TIMEOUT, 32'd0);
    send_item(mtw_pkg::ACT_REGISTER, 8'h42, 16'd0);
    send_item(mtw_pkg::ACT_SCAN, 8'h00, 16'd0);
    send_item(mtw_pkg::ACT_SCAN, 8'h00, 16'd1);
    wait_idle();
    write_reg(mtw_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF);
    send_item(mtw_pkg::ACT_REGISTER, 8'h24, 16'd0);
    send_item(mtw_pkg::ACT_SCAN, 8'h00, 16'hFFFF);
    wait_idle();
    write_reg(mtw_pkg::CFG_TIMEOUT, 32'd1);
    send_item(mtw_pkg::ACT_SCAN, 8'h00, 16'd0);
    send_item(mtw_pkg::ACT_REGISTER, 8'h81, 16'd0);
    send_item(mtw_pkg::ACT_SCAN, 8'h00, 16'd1);
    send_item(mtw_pkg::ACT_SCAN, 8'h00, 16'd1);
    wait_idle();
  endtask

  task automatic test_long_gaps();
    write_reg(mtw_pkg::CFG_TIMEOUT, 32'd100000);
    send_item(mtw_pkg::ACT_REGISTER, 8'h3C, 16'd0);
    send_item(mtw_pkg::ACT_SCAN, 8'h00, 16'd0);
    send_item(mtw_pkg::ACT_NONE, 8'h00, 16'd1000);
    send_item(mtw_pkg::ACT_SCAN, 8'h00, 16'd0);
    send_item(mtw_pkg::ACT_NONE, 8'h00, 16'hFFFF);
    send_item(mtw_pkg::ACT_NONE, 8'h00, 16'd40000);
    send_item(mtw_pkg::ACT_SCAN, 8'h00, 16'd0);
    wait_idle();
  endtask

  task automatic test_backpressure();
    int i;
    write_reg(mtw_pkg::CFG_TIMEOUT, 32'd50);
    hold_left = 400;
    for (i = 0; i < 18; i++) begin
      send_item(mtw_pkg::ACT_REGISTER, mtw_pkg::ID_W'($urandom_range(0, 255)), 16'd0);
    end
    send_item(mtw_pkg::ACT_SCAN, 8'h00, 16'd1000);
    for (i = 0; i < 6; i++) begin
      send_item(mtw_pkg::ACT_CHECKIN, mtw_pkg::ID_W'($urandom_range(0, 255)), 16'd3);
    end
    wait_idle();
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input logic [mtw_pkg::TIME_W-1:0] tmo,
                                   input logic [mtw_pkg::TIME_W-1:0] mode,
                                   input int n);
    logic [mtw_pkg::ID_W-1:0]    pool [24];
    logic [1:0]                  act;
    logic [mtw_pkg::ID_W-1:0]    id;
    logic [mtw_pkg::ELAPS_W-1:0] el;
    longint                      span;
    int                          r;
    int                          k;
    write_reg(mtw_pkg::CFG_TIMEOUT, tmo);
    write_reg(mtw_pkg::CFG_RESET_MODE, mode);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    span = longint'(tmo) / 3;
    if (span < 1) span = 1;
    if (span > 65535) span = 65535;
    for (k = 0; k < 24; k++) pool[k] = mtw_pkg::ID_W'($urandom_range(0, 255));
    for (k = 0; k < n; k++) begin
      r  = $urandom_range(0, 99);
      id = pool[$urandom_range(0, 23)];
      if (r < 36) begin
        act = mtw_pkg::ACT_REGISTER;
      end else if (r < 70) begin
        act = mtw_pkg::ACT_CHECKIN;
        if ($urandom_range(0, 9) == 0) id = mtw_pkg::ID_W'($urandom_range(0, 255));
      end else if (r < 88) begin
        act = mtw_pkg::ACT_SCAN;
      end else if (r < 94) begin
        act = mtw_pkg::ACT_NONE;
      end else begin
        act = 2'($urandom_range(0, 3));
        id  = mtw_pkg::ID_W'($urandom_range(0, 255));
      end
      r = $urandom_range(0, 99);
      if (r < 65) el = mtw_pkg::ELAPS_W'($urandom_range(0, int'(span)));
      else if (r < 80) el = '0;
      else el = mtw_pkg::ELAPS_W'($urandom_range(0, 65535));
      send_item(act, id, el);
    end
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    errors         = 0;
    items_sent     = 0;
    results_seen   = 0;
    timeouts_seen  = 0;
    resets_seen    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    tick_count     = '0;
    timeout_limit  = mtw_pkg::TIMEOUT_DEFAULT;
    reset_mode     = 1'b0;
    tbl_len        = 0;
    rst_n            = 1'b0;
    in_chan.valid    = 1'b0;
    in_chan.action   = mtw_pkg::ACT_NONE;
    in_chan.task_id  = '0;
    in_chan.elapsed  = '0;
    out_chan.ready   = 1'b0;
    cfg_chan.valid   = 1'b0;
    cfg_chan.index   = mtw_pkg::CFG_TIMEOUT;
    cfg_chan.data    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    send_idle_pct  = 38;
    recv_stall_pct = 38;
    test_table_basics();
    test_reset_mode();
    test_timeout_extremes();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_long_gaps();
    test_backpressure();
    test_random_phase(0, 0, 32'd2500, 32'd0, 48);
    test_random_phase(80, 0, 32'd600, 32'd1, 48);
    test_random_phase(0, 80, mtw_pkg::TIME_W'($urandom_range(1, 8000)), $urandom() & ~32'd1,
                      48);
    test_random_phase(38, 38, 32'd1500, mtw_pkg::TIME_W'($urandom_range(0, 1)), 48);

    $display("Run covered %0d accepted items and %0d results, with %0d timeout reports",
             items_sent, results_seen, timeouts_seen);
    $display("and %0d reset requests, over table fill, long gaps, stalls and idling.",
             resets_seen);
    if (errors == 0) begin
      $display("multi_task_watchdog_core test passed");
    end else begin
      $display("multi_task_watchdog_core test failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("%0t: run did not complete in time", $time);
    $display("multi_task_watchdog_core test failed");
    $finish;
  end

endmodule
